@@ rtl/core/pbb_pkg.sv @@
`default_nettype none
package pbb_pkg;

  typedef logic signed [63:0] coord_t;
  typedef logic [1:0]         kind_t;
  typedef logic [1:0]         count_t;

  // Input item kinds
  localparam kind_t KIND_POINT = 2'd0;
  localparam kind_t KIND_EMPTY = 2'd1;
  localparam kind_t KIND_END   = 2'd2;

  // Result kinds
  localparam kind_t RES_BOX     = 2'd0;
  localparam kind_t RES_SUMMARY = 2'd1;
  localparam kind_t RES_ERROR   = 2'd2;

  // Point counter saturation and shape thresholds
  localparam count_t COUNT_SAT     = 2'd3;
  localparam count_t POLYGON_MIN   = 2'd3;
  localparam count_t LINE_MIN      = 2'd2;

  // Box bounds for an empty path
  localparam coord_t COORD_MAX_S64 = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam coord_t COORD_MIN_S64 = 64'sh8000_0000_0000_0000;

  // Register map and reset values
  localparam int     ADDR_W          = 4;
  localparam logic   REG_COORD_MIN   = 1'b0;
  localparam logic   REG_COORD_MAX   = 1'b1;
  localparam coord_t COORD_MIN_RESET = 64'shE000_0000_0000_0001;
  localparam coord_t COORD_MAX_RESET = 64'sh1FFF_FFFF_FFFF_FFFF;

endpackage
`default_nettype wire

@@ rtl/core/pbb_in_if.sv @@
`default_nettype none
interface pbb_in_if
  import pbb_pkg::*;
();
  logic   valid;
  logic   ready;
  kind_t  kind;
  coord_t px;
  coord_t py;
  logic   path_end;

  modport source (output valid, kind, px, py, path_end, input ready);
  modport sink   (input valid, kind, px, py, path_end, output ready);
endinterface
`default_nettype wire

@@ rtl/core/pbb_out_if.sv @@
`default_nettype none
interface pbb_out_if
  import pbb_pkg::*;
();
  logic   valid;
  logic   ready;
  kind_t  result_kind;
  coord_t box_left;
  coord_t box_top;
  coord_t box_right;
  coord_t box_bottom;
  logic   any_bounds;
  logic   all_polygon_size;
  logic   all_line_size;
  logic   set_ok;

  modport source (output valid, result_kind, box_left, box_top, box_right, box_bottom,
                  any_bounds, all_polygon_size, all_line_size, set_ok, input ready);
  modport sink   (input valid, result_kind, box_left, box_top, box_right, box_bottom,
                  any_bounds, all_polygon_size, all_line_size, set_ok, output ready);
endinterface
`default_nettype wire

@@ rtl/core/pbb_axis.sv @@
`default_nettype none
module pbb_axis
  import pbb_pkg::*;
(
  input  wire coord_t coord,
  input  wire coord_t path_min,
  input  wire coord_t path_max,
  input  wire coord_t union_min,
  input  wire coord_t union_max,
  input  wire logic   first,
  input  wire logic   union_valid,
  output coord_t      path_min_next,
  output coord_t      path_max_next,
  output coord_t      union_min_next,
  output coord_t      union_max_next
);

  logic c_lt_pmin, c_lt_umin, pmin_lt_umin;
  logic pmax_lt_c, umax_lt_c, umax_lt_pmax;
  logic take_min, take_max;
  coord_t merged_min, merged_max;

  // Run all compares side by side so the path and union updates share one level
  always_comb begin
    c_lt_pmin    = coord < path_min;
    c_lt_umin    = coord < union_min;
    pmin_lt_umin = path_min < union_min;
    pmax_lt_c    = path_max < coord;
    umax_lt_c    = union_max < coord;
    umax_lt_pmax = union_max < path_max;
  end

  // Extend the path range by the new coordinate
  always_comb begin
    take_min      = first || c_lt_pmin;
    take_max      = first || pmax_lt_c;
    path_min_next = take_min ? coord : path_min;
    path_max_next = take_max ? coord : path_max;
  end

  // Merge the updated path range into the union
  always_comb begin
    if (take_min) begin
      merged_min = c_lt_umin ? coord : union_min;
    end else begin
      merged_min = pmin_lt_umin ? path_min : union_min;
    end
    if (take_max) begin
      merged_max = umax_lt_c ? coord : union_max;
    end else begin
      merged_max = umax_lt_pmax ? path_max : union_max;
    end
    union_min_next = union_valid ? merged_min : path_min_next;
    union_max_next = union_valid ? merged_max : path_max_next;
  end

endmodule
`default_nettype wire

@@ rtl/core/path_bounding_box_engine_unit.sv @@
`default_nettype none
// Path bounding box engine.
// points carries one item per beat: a point (kind, px, py, path_end), an
// empty path marker or an end-of-set marker. results carries at most one
// result beat per input beat: a path box on the last point of a path or an
// empty marker, one range error on the first out-of-range point, and a
// summary on every end-of-set marker. After an error, points and markers
// are dropped until end of set.
// The APB port holds coord_min at address 0 and coord_max at address 8;
// write them only while no beat is in flight.
// A beat accepted into the input register is worked on there and its result
// is loaded into the result register, which drives results.
// One beat is accepted per cycle while results is not stalled; the limit is
// the combinational update of the running path and union boxes between the
// input and result registers. Reset clears path and union state, sets shape
// flags and loads default range. When results is stalled, the result register
// holds and the input register fills, then points.ready drops until taken.
module path_bounding_box_engine_unit
  import pbb_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  pbb_in_if.sink                 points,
  pbb_out_if.source              results,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [63:0]       pwdata,
  output logic [63:0]            prdata,
  output logic                   pready
);

  // Configuration registers
  coord_t coord_min, coord_max;

  // Input register
  logic   s1_valid;
  kind_t  s1_kind;
  coord_t s1_px, s1_py;
  logic   s1_last;

  // Path and set state
  coord_t path_min_x, path_min_y, path_max_x, path_max_y;
  coord_t union_left, union_top, union_right, union_bottom;
  count_t points_seen;
  logic   union_valid, polygon_flag, line_flag, failed;

  coord_t path_min_x_next, path_min_y_next, path_max_x_next, path_max_y_next;
  coord_t union_left_next, union_top_next, union_right_next, union_bottom_next;
  count_t points_seen_next, count_sat;
  logic   union_valid_next, polygon_flag_next, line_flag_next, failed_next;

  // Axis updates
  coord_t ax_pmin_x, ax_pmax_x, ax_umin_x, ax_umax_x;
  coord_t ax_pmin_y, ax_pmax_y, ax_umin_y, ax_umax_y;
  logic   first, in_range;

  // Result register
  logic   res_valid;
  kind_t  res_kind;
  coord_t res_left, res_top, res_right, res_bottom;
  logic   res_any, res_poly, res_line, res_ok;

  logic   emit;
  kind_t  emit_kind;
  coord_t emit_left, emit_top, emit_right, emit_bottom;
  logic   emit_any, emit_poly, emit_line, emit_ok;

  logic   go, in_beat, cfg_write;

  // APB register access
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[3])
      REG_COORD_MIN: prdata = coord_min;
      REG_COORD_MAX: prdata = coord_max;
      default:       prdata = coord_min;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coord_min <= COORD_MIN_RESET;
      coord_max <= COORD_MAX_RESET;
    end else if (cfg_write) begin
      if (paddr[3] == REG_COORD_MIN) begin
        coord_min <= pwdata;
      end else begin
        coord_max <= pwdata;
      end
    end
  end

  // Handshake: the input stage moves on whenever the result slot is free
  assign go           = s1_valid && (!res_valid || results.ready);
  assign points.ready = !s1_valid || go;
  assign in_beat      = points.valid && points.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_beat) begin
      s1_valid <= 1'b1;
    end else if (go) begin
      s1_valid <= 1'b0;
    end
  end

  // Capture the input beat
  always_ff @(posedge clk) begin
    if (in_beat) begin
      s1_kind <= points.kind;
      s1_px   <= points.px;
      s1_py   <= points.py;
      s1_last <= points.path_end;
    end
  end

  assign first    = (points_seen == '0);
  assign in_range = (s1_px >= coord_min) && (s1_px <= coord_max) &&
                    (s1_py >= coord_min) && (s1_py <= coord_max);
  assign count_sat = (points_seen == COUNT_SAT) ? COUNT_SAT : points_seen + 2'd1;

  pbb_axis u_axis_x (
    .coord          (s1_px),
    .path_min       (path_min_x),
    .path_max       (path_max_x),
    .union_min      (union_left),
    .union_max      (union_right),
    .first          (first),
    .union_valid    (union_valid),
    .path_min_next  (ax_pmin_x),
    .path_max_next  (ax_pmax_x),
    .union_min_next (ax_umin_x),
    .union_max_next (ax_umax_x)
  );

  pbb_axis u_axis_y (
    .coord          (s1_py),
    .path_min       (path_min_y),
    .path_max       (path_max_y),
    .union_min      (union_top),
    .union_max      (union_bottom),
    .first          (first),
    .union_valid    (union_valid),
    .path_min_next  (ax_pmin_y),
    .path_max_next  (ax_pmax_y),
    .union_min_next (ax_umin_y),
    .union_max_next (ax_umax_y)
  );

  // Work out the next state and the result for the registered beat
  always_comb begin
    path_min_x_next   = path_min_x;
    path_min_y_next   = path_min_y;
    path_max_x_next   = path_max_x;
    path_max_y_next   = path_max_y;
    union_left_next   = union_left;
    union_top_next    = union_top;
    union_right_next  = union_right;
    union_bottom_next = union_bottom;
    points_seen_next  = points_seen;
    union_valid_next  = union_valid;
    polygon_flag_next = polygon_flag;
    line_flag_next    = line_flag;
    failed_next       = failed;
    emit        = 1'b0;
    emit_kind   = RES_BOX;
    emit_left   = '0;
    emit_top    = '0;
    emit_right  = '0;
    emit_bottom = '0;
    emit_any    = 1'b0;
    emit_poly   = 1'b0;
    emit_line   = 1'b0;
    emit_ok     = 1'b0;
    if (go) begin
      unique case (s1_kind)
        KIND_END: begin
          emit      = 1'b1;
          emit_kind = RES_SUMMARY;
          if (!failed) begin
            emit_ok   = 1'b1;
            emit_poly = polygon_flag;
            emit_line = line_flag;
            if (union_valid) begin
              emit_any    = 1'b1;
              emit_left   = union_left;
              emit_top    = union_top;
              emit_right  = union_right;
              emit_bottom = union_bottom;
            end
          end
          points_seen_next  = '0;
          union_valid_next  = 1'b0;
          polygon_flag_next = 1'b1;
          line_flag_next    = 1'b1;
          failed_next       = 1'b0;
        end
        KIND_EMPTY: begin
          if (!failed) begin
            points_seen_next  = '0;
            polygon_flag_next = 1'b0;
            line_flag_next    = 1'b0;
            emit        = 1'b1;
            emit_kind   = RES_BOX;
            emit_left   = COORD_MAX_S64;
            emit_top    = COORD_MAX_S64;
            emit_right  = COORD_MIN_S64;
            emit_bottom = COORD_MIN_S64;
          end
        end
        KIND_POINT: begin
          if (!failed) begin
            if (!in_range) begin
              failed_next      = 1'b1;
              points_seen_next = '0;
              emit             = 1'b1;
              emit_kind        = RES_ERROR;
            end else begin
              path_min_x_next  = ax_pmin_x;
              path_max_x_next  = ax_pmax_x;
              path_min_y_next  = ax_pmin_y;
              path_max_y_next  = ax_pmax_y;
              points_seen_next = count_sat;
              if (s1_last) begin
                if (count_sat < POLYGON_MIN) polygon_flag_next = 1'b0;
                if (count_sat < LINE_MIN)    line_flag_next    = 1'b0;
                union_left_next   = ax_umin_x;
                union_right_next  = ax_umax_x;
                union_top_next    = ax_umin_y;
                union_bottom_next = ax_umax_y;
                union_valid_next  = 1'b1;
                points_seen_next  = '0;
                emit        = 1'b1;
                emit_kind   = RES_BOX;
                emit_left   = ax_pmin_x;
                emit_top    = ax_pmin_y;
                emit_right  = ax_pmax_x;
                emit_bottom = ax_pmax_y;
              end
            end
          end
        end
        default: begin
          // unused kind: drop the beat
        end
      endcase
    end
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (rst) begin
      points_seen  <= '0;
      union_valid  <= 1'b0;
      polygon_flag <= 1'b1;
      line_flag    <= 1'b1;
      failed       <= 1'b0;
    end else begin
      points_seen  <= points_seen_next;
      union_valid  <= union_valid_next;
      polygon_flag <= polygon_flag_next;
      line_flag    <= line_flag_next;
      failed       <= failed_next;
    end
  end

  // Hold box data; only read while the matching control state says so
  always_ff @(posedge clk) begin
    path_min_x   <= path_min_x_next;
    path_min_y   <= path_min_y_next;
    path_max_x   <= path_max_x_next;
    path_max_y   <= path_max_y_next;
    union_left   <= union_left_next;
    union_top    <= union_top_next;
    union_right  <= union_right_next;
    union_bottom <= union_bottom_next;
  end

  // Result register: load on emit, drop once the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res_kind   <= emit_kind;
      res_left   <= emit_left;
      res_top    <= emit_top;
      res_right  <= emit_right;
      res_bottom <= emit_bottom;
      res_any    <= emit_any;
      res_poly   <= emit_poly;
      res_line   <= emit_line;
      res_ok     <= emit_ok;
    end
  end

  assign results.valid            = res_valid;
  assign results.result_kind      = res_kind;
  assign results.box_left         = res_left;
  assign results.box_top          = res_top;
  assign results.box_right        = res_right;
  assign results.box_bottom       = res_bottom;
  assign results.any_bounds       = res_any;
  assign results.all_polygon_size = res_poly;
  assign results.all_line_size    = res_line;
  assign results.set_ok           = res_ok;

endmodule
`default_nettype wire
